>>> rtl/core/mrp_pkg.sv
// Shared types and constants of the free-rectangle placer.
package mrp_pkg;

  localparam int BOX_BITS      = 16;
  localparam int CFG_ADDR_BITS = 2;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 72;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_BIN_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_FIT_RULE   = 2'd2;

  localparam logic [BOX_BITS-1:0] BIN_WIDTH_RST  = 16'd1024;
  localparam logic [BOX_BITS-1:0] BIN_HEIGHT_RST = 16'hFFFF;
  localparam logic [BOX_BITS-1:0] STRIP_MAX      = 16'hFFFF;

  localparam logic FIT_BOTTOM_LEFT = 1'b0;
  localparam logic FIT_SHORT_SIDE  = 1'b1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT,
    CMD_RD_A,
    CMD_FIT_EVAL,
    CMD_FIT_NEXT,
    CMD_DECIDE,
    CMD_P1_EVAL,
    CMD_P2_START,
    CMD_P2_HOLD,
    CMD_P2_SKIP,
    CMD_P2_PUSH,
    CMD_PR_START,
    CMD_RD_B,
    CMD_RD_BJ,
    CMD_PR_HOLDI,
    CMD_PR_NEXTI,
    CMD_PR_EVALJ,
    CMD_CP_START,
    CMD_CP_EVAL,
    CMD_OUT
  } mrp_cmd_t;

  typedef struct packed {
    logic a_end;
    logic b_end;
    logic j_end;
    logic phase;
    logic new_job;
    logic isect;
    logic b_dead;
    logic j_in_i;
    logic i_in_j;
    logic sub_last;
    logic place_ok;
    logic out_busy;
  } mrp_stat_t;

endpackage

>>> rtl/core/maxrects_rectangle_placer_top.sv
// One item at a time: a new item is taken only after the last result is loaded for output.
// The pairwise prune over the split list, on the single read port of the work list memory,
// dominates the time per item; an unplaced box skips the split, prune and compaction passes.
// Reset: rst_n, synchronous and active low, empties the free list, clears the strip height
// and the sticky overflow flag, and loads the default bin size and fit rule.
module maxrects_rectangle_placer_top #(
  parameter int FREE_SLOTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: box_id [15:0], box_width [31:16], box_height [47:32]
  input  logic [mrp_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // in_tuser: new_job
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: placed [0], pos_x [16:1], pos_y [32:17], rotated [33], box_tag [49:34],
  //            strip_height [65:50], list_overflow [66], zero fill [71:67]
  output logic [mrp_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [mrp_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [mrp_pkg::BOX_BITS-1:0]       cfg_wdata
);

  // Each item: score both orientations over the list; if the box is placed, copy untouched entries
  // into the work list, append the split remainders, mark contained entries dead, and compact back.
  mrp_pkg::mrp_cmd_t  cmd;
  mrp_pkg::mrp_stat_t stat;

  mrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mrp_dpath #(
    .FREE_SLOTS (FREE_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/core/mrp_ram.sv
// Generic simple dual-port RAM with registered read.
module mrp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mrp_ctrl.sv
// Sequencer of the placer: fit scan, split passes, prune and compaction.
module mrp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  mrp_pkg::mrp_stat_t  stat,
  output mrp_pkg::mrp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_FIT_RD, S_FIT_EV, S_DECIDE, S_P1_RD, S_P1_EV,
    S_P2_RD, S_P2_EV, S_P2_PUSH, S_PR_IRD, S_PR_IEV, S_PR_JRD, S_PR_JEV,
    S_CP_RD, S_CP_EV, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = mrp_pkg::CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = mrp_pkg::CMD_LOAD;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.new_job) cmd = mrp_pkg::CMD_INIT;
        state_nxt = S_FIT_RD;
      end
      S_FIT_RD: begin
        if (stat.a_end) begin
          if (stat.phase) begin
            state_nxt = S_DECIDE;
          end else begin
            cmd = mrp_pkg::CMD_FIT_NEXT;
          end
        end else begin
          cmd       = mrp_pkg::CMD_RD_A;
          state_nxt = S_FIT_EV;
        end
      end
      S_FIT_EV: begin
        cmd       = mrp_pkg::CMD_FIT_EVAL;
        state_nxt = S_FIT_RD;
      end
      S_DECIDE: begin
        cmd       = mrp_pkg::CMD_DECIDE;
        state_nxt = stat.place_ok ? S_P1_RD : S_DONE;
      end
      S_P1_RD: begin
        if (stat.a_end) begin
          cmd       = mrp_pkg::CMD_P2_START;
          state_nxt = S_P2_RD;
        end else begin
          cmd       = mrp_pkg::CMD_RD_A;
          state_nxt = S_P1_EV;
        end
      end
      S_P1_EV: begin
        cmd       = mrp_pkg::CMD_P1_EVAL;
        state_nxt = S_P1_RD;
      end
      S_P2_RD: begin
        if (stat.a_end) begin
          cmd       = mrp_pkg::CMD_PR_START;
          state_nxt = S_PR_IRD;
        end else begin
          cmd       = mrp_pkg::CMD_RD_A;
          state_nxt = S_P2_EV;
        end
      end
      S_P2_EV: begin
        if (stat.isect) begin
          cmd       = mrp_pkg::CMD_P2_HOLD;
          state_nxt = S_P2_PUSH;
        end else begin
          cmd       = mrp_pkg::CMD_P2_SKIP;
          state_nxt = S_P2_RD;
        end
      end
      S_P2_PUSH: begin
        cmd = mrp_pkg::CMD_P2_PUSH;
        if (stat.sub_last) state_nxt = S_P2_RD;
      end
      S_PR_IRD: begin
        if (stat.b_end) begin
          cmd       = mrp_pkg::CMD_CP_START;
          state_nxt = S_CP_RD;
        end else begin
          cmd       = mrp_pkg::CMD_RD_B;
          state_nxt = S_PR_IEV;
        end
      end
      S_PR_IEV: begin
        if (stat.b_dead) begin
          cmd       = mrp_pkg::CMD_PR_NEXTI;
          state_nxt = S_PR_IRD;
        end else begin
          cmd       = mrp_pkg::CMD_PR_HOLDI;
          state_nxt = S_PR_JRD;
        end
      end
      S_PR_JRD: begin
        if (stat.j_end) begin
          cmd       = mrp_pkg::CMD_PR_NEXTI;
          state_nxt = S_PR_IRD;
        end else begin
          cmd       = mrp_pkg::CMD_RD_BJ;
          state_nxt = S_PR_JEV;
        end
      end
      S_PR_JEV: begin
        cmd = mrp_pkg::CMD_PR_EVALJ;
        if (!stat.b_dead && !stat.j_in_i && stat.i_in_j) begin
          state_nxt = S_PR_IRD;
        end else begin
          state_nxt = S_PR_JRD;
        end
      end
      S_CP_RD: begin
        if (stat.b_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd       = mrp_pkg::CMD_RD_B;
          state_nxt = S_CP_EV;
        end
      end
      S_CP_EV: begin
        cmd       = mrp_pkg::CMD_CP_EVAL;
        state_nxt = S_CP_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd       = mrp_pkg::CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

>>> rtl/core/mrp_dpath.sv
// Datapath of the placer: free lists, scoring, splitting and pruning logic.
module mrp_dpath #(
  parameter int FREE_SLOTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mrp_pkg::mrp_cmd_t                   cmd,
  output mrp_pkg::mrp_stat_t                  stat,
  input  logic [mrp_pkg::IN_DATA_BITS-1:0]    in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_we,
  input  logic [mrp_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [mrp_pkg::BOX_BITS-1:0]        cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mrp_pkg::OUT_DATA_BITS-1:0]   out_tdata
);

  localparam int CW = COORD_BITS;
  localparam int BB = mrp_pkg::BOX_BITS;
  localparam int XW = ((CW > BB) ? CW : BB) + 2;
  localparam int AW = $clog2(FREE_SLOTS);
  localparam int NW = $clog2(FREE_SLOTS + 1);
  localparam int RW = 4 * CW;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
  } rect_t;

  function automatic logic [XW-1:0] ext(input logic [CW-1:0] v);
    ext = {{(XW-CW){1'b0}}, v};
  endfunction

  function automatic logic [XW-1:0] ext16(input logic [BB-1:0] v);
    ext16 = {{(XW-BB){1'b0}}, v};
  endfunction

  function automatic logic [CW-1:0] trc(input logic [XW-1:0] v);
    trc = v[CW-1:0];
  endfunction

  function automatic logic [BB-1:0] to_box(input logic [CW-1:0] v);
    logic [XW-1:0] t;
    t      = ext(v);
    to_box = t[BB-1:0];
  endfunction

  // configuration
  logic [BB-1:0] bin_w_r, bin_h_r;
  logic          fit_r;

  // item and loop state
  logic          job_r;
  logic [BB-1:0] id_r, bw_r, bh_r;
  logic [NW-1:0] cnt_r, bcnt_r, idx_r, jdx_r, kc_r, push_r, live_r;
  logic          phase_r;
  logic [1:0]    sub_r;
  logic          ok_r [2];
  logic [XW-1:0] s1_r [2];
  logic [XW-1:0] s2_r [2];
  logic [CW-1:0] px_r [2];
  logic [CW-1:0] py_r [2];
  logic [CW-1:0] ux_r, uy_r;
  logic [XW-1:0] ur_r, ut_r;
  rect_t         hold_r;
  logic [XW-1:0] hr_r, ht_r;
  logic [BB-1:0] max_top_r;
  logic          ovf_r;

  // staged and presented result
  logic          res_placed_r, res_rot_r;
  logic [BB-1:0] res_x_r, res_y_r;
  logic          out_valid_r, o_placed_r, o_rot_r, o_ovf_r;
  logic [BB-1:0] o_x_r, o_y_r, o_tag_r, o_strip_r;

  // memories
  logic          a_we, a_re, b_we, b_re;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  logic [RW-1:0] a_wdata, a_rdata;
  logic [RW:0]   b_wdata, b_rdata;

  mrp_ram #(.WIDTH(RW), .DEPTH(FREE_SLOTS)) u_list_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  mrp_ram #(.WIDTH(RW + 1), .DEPTH(FREE_SLOTS)) u_list_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  rect_t fa, fb, pr, bin_rect;
  logic  fb_dead;
  assign fa      = rect_t'(a_rdata);
  assign fb      = rect_t'(b_rdata[RW-1:0]);
  assign fb_dead = b_rdata[RW];

  // fit scoring
  logic [BB-1:0] cw16, ch16;
  logic [XW-1:0] cwx, chx, lh, lv, sa, sb;
  logic          fit, better;
  always_comb begin
    cw16   = phase_r ? bh_r : bw_r;
    ch16   = phase_r ? bw_r : bh_r;
    cwx    = ext16(cw16);
    chx    = ext16(ch16);
    fit    = (cw16 != '0) && (ch16 != '0) && (ext(fa.w) >= cwx) && (ext(fa.h) >= chx);
    lh     = ext(fa.w) - cwx;
    lv     = ext(fa.h) - chx;
    if (fit_r == mrp_pkg::FIT_SHORT_SIDE) begin
      sa = (lh < lv) ? lh : lv;
      sb = (lh < lv) ? lv : lh;
    end else begin
      sa = ext(fa.y) + chx;
      sb = ext(fa.x);
    end
    better = !ok_r[phase_r] || (sa < s1_r[phase_r]) ||
             ((sa == s1_r[phase_r]) && (sb < s2_r[phase_r]));
  end

  // orientation choice
  logic          rot_c, place_ok;
  logic [CW-1:0] sx, sy;
  logic [BB-1:0] pw, ph;
  logic [XW-1:0] top;
  logic [BB-1:0] top_sat;
  always_comb begin
    rot_c    = ok_r[1] && (!ok_r[0] || (s1_r[1] < s1_r[0]) ||
               ((s1_r[1] == s1_r[0]) && (s2_r[1] < s2_r[0])));
    place_ok = ok_r[0] || ok_r[1];
    sx       = rot_c ? px_r[1] : px_r[0];
    sy       = rot_c ? py_r[1] : py_r[0];
    pw       = rot_c ? bh_r : bw_r;
    ph       = rot_c ? bw_r : bh_r;
    top      = ext(sy) + ext16(ph);
    top_sat  = (top > ext16(mrp_pkg::STRIP_MAX)) ? mrp_pkg::STRIP_MAX : top[BB-1:0];
  end

  // overlap of the scanned free rectangle with the placed box
  logic [XW-1:0] far, fat;
  logic          isect;
  always_comb begin
    far   = ext(fa.x) + ext(fa.w);
    fat   = ext(fa.y) + ext(fa.h);
    isect = !((ext(ux_r) >= far) || (ur_r <= ext(fa.x)) ||
              (ext(uy_r) >= fat) || (ut_r <= ext(fa.y)));
  end

  // remainders: below, above, left, right
  logic pc, room, do_push, sub_last;
  always_comb begin
    pr = hold_r;
    pc = 1'b0;
    case (sub_r)
      2'd0: begin
        pc   = (ext(uy_r) > ext(hold_r.y)) && (ext(uy_r) < ht_r);
        pr.h = trc(ext(uy_r) - ext(hold_r.y));
      end
      2'd1: begin
        pc   = ut_r < ht_r;
        pr.y = trc(ut_r);
        pr.h = trc(ht_r - ut_r);
      end
      2'd2: begin
        pc   = (ext(ux_r) > ext(hold_r.x)) && (ext(ux_r) < hr_r);
        pr.w = trc(ext(ux_r) - ext(hold_r.x));
      end
      default: begin
        pc   = ur_r < hr_r;
        pr.x = trc(ur_r);
        pr.w = trc(hr_r - ur_r);
      end
    endcase
    room     = live_r < NW'(FREE_SLOTS);
    do_push  = pc && room;
    sub_last = (sub_r == 2'd3);
  end

  // containment between held entry i and scanned entry j
  logic [XW-1:0] jr, jt;
  logic          j_in_i, i_in_j;
  always_comb begin
    jr     = ext(fb.x) + ext(fb.w);
    jt     = ext(fb.y) + ext(fb.h);
    j_in_i = (fb.x >= hold_r.x) && (fb.y >= hold_r.y) && (jr <= hr_r) && (jt <= ht_r);
    i_in_j = (hold_r.x >= fb.x) && (hold_r.y >= fb.y) && (hr_r <= jr) && (ht_r <= jt);
  end

  logic [NW-1:0] push_addr;
  assign push_addr = kc_r + push_r;

  always_comb begin
    bin_rect.x = '0;
    bin_rect.y = '0;
    bin_rect.w = trc(ext16(bin_w_r));
    bin_rect.h = trc(ext16(bin_h_r));
  end

  // memory ports
  always_comb begin
    a_re    = (cmd == mrp_pkg::CMD_RD_A);
    a_raddr = idx_r[AW-1:0];
    a_we    = 1'b0;
    a_waddr = cnt_r[AW-1:0];
    a_wdata = fb;
    b_re    = (cmd == mrp_pkg::CMD_RD_B) || (cmd == mrp_pkg::CMD_RD_BJ);
    b_raddr = (cmd == mrp_pkg::CMD_RD_BJ) ? jdx_r[AW-1:0] : idx_r[AW-1:0];
    b_we    = 1'b0;
    b_waddr = kc_r[AW-1:0];
    b_wdata = {1'b0, fa};
    case (cmd)
      mrp_pkg::CMD_INIT: begin
        a_we    = 1'b1;
        a_waddr = '0;
        a_wdata = bin_rect;
      end
      mrp_pkg::CMD_CP_EVAL: a_we = !fb_dead;
      mrp_pkg::CMD_P1_EVAL: b_we = !isect;
      mrp_pkg::CMD_P2_PUSH: begin
        b_we    = do_push;
        b_waddr = push_addr[AW-1:0];
        b_wdata = {1'b0, pr};
      end
      mrp_pkg::CMD_PR_EVALJ: begin
        if (!fb_dead && j_in_i) begin
          b_we    = 1'b1;
          b_waddr = jdx_r[AW-1:0];
          b_wdata = {1'b1, fb};
        end else if (!fb_dead && i_in_j) begin
          b_we    = 1'b1;
          b_waddr = idx_r[AW-1:0];
          b_wdata = {1'b1, hold_r};
        end
      end
      default: ;
    endcase
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_w_r     <= mrp_pkg::BIN_WIDTH_RST;
      bin_h_r     <= mrp_pkg::BIN_HEIGHT_RST;
      fit_r       <= mrp_pkg::FIT_BOTTOM_LEFT;
      cnt_r       <= '0;
      max_top_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mrp_pkg::CFG_BIN_WIDTH:  bin_w_r <= cfg_wdata;
          mrp_pkg::CFG_BIN_HEIGHT: bin_h_r <= cfg_wdata;
          mrp_pkg::CFG_FIT_RULE:   fit_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd == mrp_pkg::CMD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        mrp_pkg::CMD_INIT: begin
          cnt_r     <= NW'(1);
          max_top_r <= '0;
        end
        mrp_pkg::CMD_DECIDE: begin
          if (place_ok && (top_sat > max_top_r)) max_top_r <= top_sat;
        end
        mrp_pkg::CMD_P2_PUSH: begin
          if (pc && !room) ovf_r <= 1'b1;
        end
        mrp_pkg::CMD_CP_START: cnt_r <= '0;
        mrp_pkg::CMD_CP_EVAL: begin
          if (!fb_dead) cnt_r <= cnt_r + NW'(1);
        end
        default: ;
      endcase
    end
  end

  // working registers, set up by commands before use
  always_ff @(posedge clk) begin
    case (cmd)
      mrp_pkg::CMD_LOAD: begin
        job_r   <= in_tuser;
        id_r    <= in_tdata[BB-1:0];
        bw_r    <= in_tdata[2*BB-1:BB];
        bh_r    <= in_tdata[3*BB-1:2*BB];
        idx_r   <= '0;
        phase_r <= 1'b0;
        ok_r[0] <= 1'b0;
        ok_r[1] <= 1'b0;
      end
      mrp_pkg::CMD_FIT_EVAL: begin
        if (fit && better) begin
          ok_r[phase_r] <= 1'b1;
          s1_r[phase_r] <= sa;
          s2_r[phase_r] <= sb;
          px_r[phase_r] <= fa.x;
          py_r[phase_r] <= fa.y;
        end
        idx_r <= idx_r + NW'(1);
      end
      mrp_pkg::CMD_FIT_NEXT: begin
        phase_r <= 1'b1;
        idx_r   <= '0;
      end
      mrp_pkg::CMD_DECIDE: begin
        res_placed_r <= place_ok;
        res_rot_r    <= place_ok && rot_c;
        res_x_r      <= place_ok ? to_box(sx) : '0;
        res_y_r      <= place_ok ? to_box(sy) : '0;
        ux_r         <= sx;
        uy_r         <= sy;
        ur_r         <= ext(sx) + ext16(pw);
        ut_r         <= top;
        idx_r        <= '0;
        kc_r         <= '0;
      end
      mrp_pkg::CMD_P1_EVAL: begin
        if (!isect) kc_r <= kc_r + NW'(1);
        idx_r <= idx_r + NW'(1);
      end
      mrp_pkg::CMD_P2_START: begin
        idx_r  <= '0;
        push_r <= '0;
        live_r <= cnt_r;
      end
      mrp_pkg::CMD_P2_HOLD: begin
        hold_r <= fa;
        hr_r   <= far;
        ht_r   <= fat;
        sub_r  <= 2'd0;
      end
      mrp_pkg::CMD_P2_SKIP: idx_r <= idx_r + NW'(1);
      mrp_pkg::CMD_P2_PUSH: begin
        if (do_push) push_r <= push_r + NW'(1);
        live_r <= live_r + {{(NW-1){1'b0}}, do_push} - {{(NW-1){1'b0}}, sub_last};
        if (sub_last) idx_r <= idx_r + NW'(1);
        sub_r <= sub_r + 2'd1;
      end
      mrp_pkg::CMD_PR_START: begin
        bcnt_r <= live_r;
        idx_r  <= '0;
      end
      mrp_pkg::CMD_PR_HOLDI: begin
        hold_r <= fb;
        hr_r   <= jr;
        ht_r   <= jt;
        jdx_r  <= idx_r + NW'(1);
      end
      mrp_pkg::CMD_PR_NEXTI: idx_r <= idx_r + NW'(1);
      mrp_pkg::CMD_PR_EVALJ: begin
        if (!fb_dead && !j_in_i && i_in_j) begin
          idx_r <= idx_r + NW'(1);
        end else begin
          jdx_r <= jdx_r + NW'(1);
        end
      end
      mrp_pkg::CMD_CP_START: idx_r <= '0;
      mrp_pkg::CMD_CP_EVAL:  idx_r <= idx_r + NW'(1);
      mrp_pkg::CMD_OUT: begin
        o_placed_r <= res_placed_r;
        o_x_r      <= res_x_r;
        o_y_r      <= res_y_r;
        o_rot_r    <= res_rot_r;
        o_tag_r    <= id_r;
        o_strip_r  <= max_top_r;
        o_ovf_r    <= ovf_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat          = '0;
    stat.a_end    = idx_r >= cnt_r;
    stat.b_end    = idx_r >= bcnt_r;
    stat.j_end    = jdx_r >= bcnt_r;
    stat.phase    = phase_r;
    stat.new_job  = job_r;
    stat.isect    = isect;
    stat.b_dead   = fb_dead;
    stat.j_in_i   = j_in_i;
    stat.i_in_j   = i_in_j;
    stat.sub_last = sub_last;
    stat.place_ok = place_ok;
    stat.out_busy = out_valid_r && !out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, o_ovf_r, o_strip_r, o_tag_r, o_rot_r, o_y_r, o_x_r, o_placed_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(FREE_SLOTS))
    else $error("free list count above capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == mrp_pkg::CMD_P2_PUSH) |-> (push_addr <= live_r))
    else $error("remainder write address beyond live count");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == mrp_pkg::CMD_OUT) |=> out_valid_r)
    else $error("result not presented after load");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the free-rectangle box placer.
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic [mrp_pkg::CFG_ADDR_BITS-1:0] CFG_SPARE_IDX = 2'd3;

  // One placement result as the block reports it.
  typedef struct {
    logic        placed;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        rotated;
    logic [15:0] box_tag;
    logic [15:0] strip_height;
    logic        list_overflow;
  } placement_t;

  typedef struct {
    longint x, y, w, h;
  } free_rect_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic [mrp_pkg::IN_DATA_BITS-1:0]    in_tdata = '0;
  logic                                in_tuser = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [mrp_pkg::OUT_DATA_BITS-1:0]   out_tdata;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [mrp_pkg::CFG_ADDR_BITS-1:0]   cfg_addr = mrp_pkg::CFG_BIN_WIDTH;
  logic [mrp_pkg::BOX_BITS-1:0]        cfg_wdata = '0;

  maxrects_rectangle_placer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow state of the placer.
  free_rect_t  free_rects[$];
  longint      top_edge;
  bit          dropped_seen;
  longint      bin_w = 1024, bin_h = 65535;
  bit          short_side_rule;

  placement_t  pending_results[$];
  int          error_count;
  int          items_sent, results_seen, placed_seen, rotated_seen;
  longint      cycle_count = 0;
  bit          rx_hold;      // long receiver hold-off
  bit          rx_random = 1'b1;
  int          rx_wait = 0;  // cycles the receiver still holds off after a result

  // ---------------- predictor ----------------

  function automatic void add_free(longint x, longint y, longint w, longint h);
    free_rect_t r;
    if (free_rects.size() >= SLOTS) begin
      dropped_seen = 1'b1;
      return;
    end
    r.x = x & 16'hFFFF; r.y = y & 16'hFFFF; r.w = w & 16'hFFFF; r.h = h & 16'hFFFF;
    free_rects.insert(free_rects.size(), r);
  endfunction

  // Score every free rectangle for a w x h box; lowest (s1, s2) wins, first on ties.
  function automatic bit best_spot(longint w, longint h, output longint s1, output longint s2,
                                   output longint px, output longint py);
    bit     found;
    longint a, b, lh, lv;
    found = 1'b0;
    s1 = 0; s2 = 0; px = 0; py = 0;
    if (w == 0 || h == 0) return 1'b0;
    foreach (free_rects[k]) begin
      if (free_rects[k].w < w || free_rects[k].h < h) continue;
      if (short_side_rule) begin
        lh = free_rects[k].w - w;
        lv = free_rects[k].h - h;
        a = (lh < lv) ? lh : lv;
        b = (lh < lv) ? lv : lh;
      end else begin
        a = free_rects[k].y + h;
        b = free_rects[k].x;
      end
      if (!found || a < s1 || (a == s1 && b < s2)) begin
        s1 = a; s2 = b; px = free_rects[k].x; py = free_rects[k].y;
        found = 1'b1;
      end
    end
    return found;
  endfunction

  function automatic bit cut_rect(free_rect_t f, longint ux, longint uy, longint uw, longint uh);
    longint fr, ft, ur, ut;
    fr = f.x + f.w; ft = f.y + f.h; ur = ux + uw; ut = uy + uh;
    if (ux >= fr || ur <= f.x || uy >= ft || ut <= f.y) return 1'b0;
    if (uy > f.y && uy < ft) add_free(f.x, f.y, f.w, uy - f.y);
    if (ut < ft) add_free(f.x, ut, f.w, ft - ut);
    if (ux > f.x && ux < fr) add_free(f.x, f.y, ux - f.x, f.h);
    if (ur < fr) add_free(ur, f.y, fr - ur, f.h);
    return 1'b1;
  endfunction

  function automatic bit contained(free_rect_t a, free_rect_t b);
    return a.x >= b.x && a.y >= b.y && a.x + a.w <= b.x + b.w && a.y + a.h <= b.y + b.h;
  endfunction

  function automatic void occupy(longint x, longint y, longint w, longint h);
    int  remaining, i, j;
    bit  drop_i;
    remaining = free_rects.size();
    i = 0;
    while (i < remaining && i < free_rects.size()) begin
      if (cut_rect(free_rects[i], x, y, w, h)) begin
        free_rects.delete(i);
        remaining--;
      end else i++;
    end
    // drop rectangles that lie inside others
    i = 0;
    while (i < free_rects.size()) begin
      drop_i = 1'b0;
      j = i + 1;
      while (j < free_rects.size()) begin
        if (contained(free_rects[j], free_rects[i])) free_rects.delete(j);
        else if (contained(free_rects[i], free_rects[j])) begin
          drop_i = 1'b1;
          break;
        end else j++;
      end
      if (drop_i) free_rects.delete(i);
      else i++;
    end
  endfunction

  function automatic placement_t place_box(bit new_job, logic [15:0] id, logic [15:0] bw,
                                           logic [15:0] bh);
    placement_t p;
    longint s1, s2, r1, r2, x, y, rx, ry, pw, ph, top;
    bit ok, rok, rot;
    if (new_job) begin
      free_rects.delete();
      top_edge = 0;
      add_free(0, 0, bin_w, bin_h);
    end
    ok  = best_spot(bw, bh, s1, s2, x, y);
    rok = best_spot(bh, bw, r1, r2, rx, ry);
    rot = 1'b0;
    if (rok && (!ok || r1 < s1 || (r1 == s1 && r2 < s2))) begin
      ok = 1'b1; rot = 1'b1; x = rx; y = ry;
    end
    if (ok) begin
      pw = rot ? bh : bw;
      ph = rot ? bw : bh;
      top = y + ph;
      occupy(x, y, pw, ph);
      if (top > 65535) top = 65535;
      if (top > top_edge) top_edge = top;
    end else begin
      x = 0; y = 0; rot = 1'b0;
    end
    p.placed = ok; p.pos_x = x[15:0]; p.pos_y = y[15:0]; p.rotated = rot; p.box_tag = id;
    p.strip_height = top_edge[15:0]; p.list_overflow = dropped_seen;
    return p;
  endfunction

  // ---------------- stimulus helpers ----------------

  // Offer one item; it stays on the bus until accepted. Valid drops only before an idle gap.
  task automatic send_box(bit new_job, logic [15:0] id, logic [15:0] bw, logic [15:0] bh,
                          bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;  // stretches with no idling
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 1'($urandom_range(0, 1));
      in_tdata  <= 48'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {bh, bw, id};
    in_tuser  <= new_job;
    in_tvalid <= 1'b1;
    pending_results.insert(pending_results.size(), place_box(new_job, id, bw, bh));
    items_sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop the input, then wait for all results plus settling time; used before register writes.
  task automatic drain();
    in_tvalid <= 1'b0;
    in_tuser  <= 1'($urandom_range(0, 1));
    in_tdata  <= 48'({$urandom, $urandom});
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [mrp_pkg::CFG_ADDR_BITS-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    case (idx)
      mrp_pkg::CFG_BIN_WIDTH:  bin_w = val;
      mrp_pkg::CFG_BIN_HEIGHT: bin_h = val;
      mrp_pkg::CFG_FIT_RULE:   short_side_rule = val[0];
      default: ;
    endcase
  endtask

  task automatic set_bin(logic [15:0] w, logic [15:0] h, logic rule);
    drain();
    write_reg(mrp_pkg::CFG_BIN_WIDTH, w);
    write_reg(mrp_pkg::CFG_BIN_HEIGHT, h);
    write_reg(mrp_pkg::CFG_FIT_RULE, {15'd0, rule});
  endtask

  function automatic logic [15:0] rand_extent(int hi);
    return 16'($urandom_range(1, hi));
  endfunction

  // ---------------- tests ----------------

  // Boxes before any job, then the reset bin defaults and field extremes.
  task automatic test_directed();
    send_box(1'b0, 16'h0000, 16'd4, 16'd4);      // no job open yet: unplaced
    send_box(1'b1, 16'hFFFF, 16'd1, 16'd1);
    send_box(1'b0, 16'h1234, 16'd1024, 16'd2);   // full width
    send_box(1'b0, 16'h5A5A, 16'd3, 16'd1025);   // taller than wide; only upright fits
    send_box(1'b0, 16'hA5A5, 16'hFFFF, 16'hFFFF); // fits nowhere
    send_box(1'b0, 16'd7, 16'd1025, 16'd1);      // only rotated fits
    send_box(1'b1, 16'd8, 16'd1024, 16'hFFFF);   // whole bin
    send_box(1'b0, 16'd9, 16'd1, 16'd1);         // bin full
    send_box(1'b1, 16'd10, 16'd100, 16'd50);
    send_box(1'b0, 16'd11, 16'd50, 16'd100);
    set_bin(16'hFFFF, 16'hFFFF, mrp_pkg::FIT_SHORT_SIDE);
    send_box(1'b1, 16'd12, 16'hFFFF, 16'd1);
    send_box(1'b0, 16'd13, 16'd1, 16'hFFFE);
    send_box(1'b0, 16'd14, 16'd100, 16'd200);
    set_bin(16'd1, 16'd1, mrp_pkg::FIT_BOTTOM_LEFT);
    send_box(1'b1, 16'd15, 16'd1, 16'd1);
    send_box(1'b0, 16'd16, 16'd1, 16'd1);
    send_box(1'b1, 16'd17, 16'd2, 16'd1);
    set_bin(16'd40, 16'hFFFF, mrp_pkg::FIT_BOTTOM_LEFT);
    send_box(1'b1, 16'd18, 16'd30, 16'hFFF0);   // tall box raises the strip close to its maximum
    send_box(1'b0, 16'd19, 16'd10, 16'd100);
  endtask

  // Jobs of random boxes under several bin settings; mostly well-formed sequences.
  task automatic test_random_jobs(int n_items);
    int left, job_len, ext;
    left = n_items;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0: set_bin(16'($urandom_range(16, 64)), 16'($urandom_range(16, 64)),
                   1'($urandom_range(0, 1)));
        1: set_bin(16'($urandom_range(100, 1024)), 16'hFFFF, 1'($urandom_range(0, 1)));
        2: set_bin(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   1'($urandom_range(0, 1)));
        default: ;
      endcase
      job_len = $urandom_range(3, 14);
      ext = (bin_w < 64) ? 24 : 300;
      send_box(1'b1, 16'($urandom), rand_extent(ext), rand_extent(ext));
      left--;
      for (int k = 1; k < job_len && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_box(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)));
        else
          send_box(1'b0, 16'($urandom), rand_extent(ext), rand_extent(ext));
        left--;
      end
    end
  endtask

  // Many tiny boxes in a wide bin fragment the free list past its capacity.
  task automatic test_list_overflow();
    set_bin(16'd2000, 16'd2000, mrp_pkg::FIT_SHORT_SIDE);
    send_box(1'b1, 16'd500, 16'd3, 16'd3);
    for (int k = 0; k < 40; k++)
      send_box(1'b0, 16'(501 + k), 16'($urandom_range(1, 7)), 16'($urandom_range(1, 7)));
  endtask

  // Hold the receiver off while the sender keeps offering, then pause until drained.
  task automatic test_backpressure();
    set_bin(16'd200, 16'd200, mrp_pkg::FIT_BOTTOM_LEFT);
    rx_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        send_box(1'b1, 16'd900, 16'd20, 16'd10, 1'b1);
        for (int k = 1; k < 8; k++)
          send_box(1'b0, 16'(900 + k), 16'($urandom_range(1, 40)),
                   16'($urandom_range(1, 40)), 1'b1);
      end
    join
    drain();
    for (int k = 0; k < 6; k++)
      send_box(1'b0, 16'(950 + k), 16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)));
  endtask

  // ---------------- checker ----------------

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    placement_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("placed",        want.placed,        out_tdata[0]);
        check_field("pos_x",         want.pos_x,         out_tdata[16:1]);
        check_field("pos_y",         want.pos_y,         out_tdata[32:17]);
        check_field("rotated",       want.rotated,       out_tdata[33]);
        check_field("box_tag",       want.box_tag,       out_tdata[49:34]);
        check_field("strip_height",  want.strip_height,  out_tdata[65:50]);
        check_field("list_overflow", want.list_overflow, out_tdata[66]);
        if (want.placed) placed_seen++;
        if (want.rotated) rotated_seen++;
      end
      // draw how long the receiver waits before taking the next item
      rx_wait = rx_random ? $urandom_range(0, 6) : 0;
    end
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Toggle random stalls on and off so there are fast stretches too.
  always begin
    repeat (500) @(posedge clk);
    rx_random = ~rx_random;
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_list_overflow();
    test_backpressure();
    test_random_jobs(215);
    // allow a gap after the last result, and a plain register write of an unused index
    drain();
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    send_box(1'b0, 16'hBEEF, 16'd1, 16'd1);
    drain();
    repeat (100) @(posedge clk);
    $display("tb_top: %0d boxes sent, %0d results, %0d placed, %0d rotated", items_sent,
             results_seen, placed_seen, rotated_seen);
    $display("covered reset defaults, both fit rules, bin extremes, list overflow, stalls");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mrp_pkg.sv
rtl/core/mrp_ram.sv
rtl/core/mrp_ctrl.sv
rtl/core/mrp_dpath.sv
rtl/core/maxrects_rectangle_placer_top.sv
verif/tb_top.sv
